// File: rtl/core/dsp_pkg.sv
// dsp_pkg: shared constants, types and register codes for the dense shortest path block.
// No dependencies. Every other file in rtl/core but dsp_ram refers to it by scoped names.
package dsp_pkg;

  localparam int MAX_NODES   = 64;
  localparam int DIST_BITS   = 40;
  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS    = $clog2(MAX_NODES + 1);
  localparam int WADDR_BITS  = 2 * NODE_BITS;
  localparam int DSTORE_BITS = DIST_BITS + 1;

  localparam int WEIGHT_BITS    = 32;
  localparam int FIELD_NODE_BITS = 6;
  localparam int NC_BITS        = 7;
  localparam int CFG_ADDR_BITS  = 2;
  localparam int CFG_DATA_BITS  = 7;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_START_NODE  = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FINISH_NODE = 2'd2;

  localparam logic [NC_BITS-1:0] NODE_COUNT_RESET = 7'd64;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // distance store entry: top bit flags infinity
  localparam logic [DSTORE_BITS-1:0] DIST_INF = {1'b1, {DIST_BITS{1'b0}}};
  localparam logic [DIST_BITS-1:0]   DIST_MAX = {DIST_BITS{1'b1}};

  typedef struct packed {
    logic [NC_BITS-1:0]         node_count;
    logic [FIELD_NODE_BITS-1:0] start_node;
    logic [FIELD_NODE_BITS-1:0] finish_node;
  } cfg_t;

  typedef struct packed {
    logic                       kind;
    logic [FIELD_NODE_BITS-1:0] row;
    logic [FIELD_NODE_BITS-1:0] col;
    logic [WEIGHT_BITS-1:0]     weight;
  } item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 reachable;
  } res_t;

endpackage

// File: rtl/core/dsp_ifs.sv
// dsp_ifs: valid/ready channel interfaces for items, results and configuration writes.
// Depends on dsp_pkg for field widths.
interface dsp_item_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [dsp_pkg::FIELD_NODE_BITS-1:0] row;
  logic [dsp_pkg::FIELD_NODE_BITS-1:0] col;
  logic signed [dsp_pkg::WEIGHT_BITS-1:0] weight;

  modport source (output valid, kind, row, col, weight, input ready);
  modport sink   (input valid, kind, row, col, weight, output ready);
endinterface

interface dsp_result_if;
  logic                          valid;
  logic                          ready;
  logic [dsp_pkg::DIST_BITS-1:0] distance;
  logic                          reachable;

  modport source (output valid, distance, reachable, input ready);
  modport sink   (input valid, distance, reachable, output ready);
endinterface

interface dsp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dsp_pkg::CFG_ADDR_BITS-1:0] addr;
  logic [dsp_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/core/dense_shortest_path_top.sv
// dense_shortest_path_top: top level, config registers, item intake and result register.
// Depends on dsp_pkg, dsp_ifs and dsp_engine.
//
// Single-source shortest path (Dijkstra, adjacency matrix form) over up to
// MAX_NODES nodes.
// items (sink): kind 0 loads one weight matrix entry (negative weight = no
//   edge), kind 1 runs a search from start_node and reports finish_node.
// results (source): one item per run: distance (saturated) and reachable;
//   distance is 0 when the finish node cannot be reached.
// cfg (sink): node_count, start_node, finish_node at indexes 0, 1, 2; always
//   ready, write only while no run is in progress.
// Loads stream back to back while the engine is idle.
// A run walks the distance RAM once per round to find the closest unvisited
// node, then the weight row and distance RAM to relax: at most n rounds plus a
// closing scan. Both RAMs have a registered read port.
// The result sits in an output register; the block takes new items while it
// waits, but a second run holds before reporting until the slot is free.
// Reset clears control state and sets node_count to 64, start/finish to 0;
// the weight matrix holds garbage until loaded.
module dense_shortest_path_top (
  input logic         clk,
  input logic         rst,
  dsp_cfg_if.sink     cfg,
  dsp_item_if.sink    items,
  dsp_result_if.source results
);

  dsp_pkg::cfg_t  cfg_regs;
  dsp_pkg::item_t item;
  dsp_pkg::res_t  res;
  logic           eng_ready;
  logic           eng_done;
  logic           accept;
  logic           out_free;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.node_count  <= dsp_pkg::NODE_COUNT_RESET;
      cfg_regs.start_node  <= '0;
      cfg_regs.finish_node <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        dsp_pkg::REG_NODE_COUNT:  cfg_regs.node_count  <= cfg.data;
        dsp_pkg::REG_START_NODE:  cfg_regs.start_node  <= cfg.data[dsp_pkg::FIELD_NODE_BITS-1:0];
        dsp_pkg::REG_FINISH_NODE: cfg_regs.finish_node <= cfg.data[dsp_pkg::FIELD_NODE_BITS-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // item intake: engine takes items only when idle
  assign items.ready = eng_ready;
  assign accept      = items.valid && eng_ready;
  assign item.kind   = items.kind;
  assign item.row    = items.row;
  assign item.col    = items.col;
  assign item.weight = items.weight;

  dsp_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .accept   (accept),
    .item     (item),
    .out_free (out_free),
    .ready    (eng_ready),
    .done     (eng_done),
    .res      (res)
  );

  // result register
  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (eng_done) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      results.distance  <= res.distance;
      results.reachable <= res.reachable;
    end
  end

endmodule

// File: rtl/core/dsp_ram.sv
// dsp_ram: simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module dsp_ram #(
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/dsp_engine.sv
// dsp_engine: search sequencer over the weight matrix RAM and the distance RAM.
// Depends on dsp_pkg and dsp_ram.
module dsp_engine (
  input  logic          clk,
  input  logic          rst,
  input  dsp_pkg::cfg_t cfg,
  input  logic          accept,
  input  dsp_pkg::item_t item,
  input  logic          out_free,
  output logic          ready,
  output logic          done,
  output dsp_pkg::res_t res
);

  localparam int NB = dsp_pkg::NODE_BITS;
  localparam int CB = dsp_pkg::CNT_BITS;
  localparam int DB = dsp_pkg::DIST_BITS;
  localparam int SB = dsp_pkg::DSTORE_BITS;
  localparam int MN = dsp_pkg::MAX_NODES;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_RELAX  = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  logic [2:0]             state;
  logic [CB-1:0]          idx;
  logic [CB-1:0]          n_r;
  logic                   pend;
  logic [NB-1:0]          pend_idx;
  logic                   pend_vis;
  logic                   pend_valid;
  logic [NB-1:0]          best;
  logic [SB-1:0]          bestd;
  logic                   found;
  logic [dsp_pkg::MAX_NODES-1:0] visited;
  logic [dsp_pkg::MAX_NODES-1:0] dvalid;

  logic [CB-1:0]          n_eff;
  logic                   run_go;
  logic                   start_ok;
  logic                   fin_ok;
  logic [NB-1:0]          start_idx;
  logic [NB-1:0]          fin_idx;
  logic                   issue;

  logic                          wt_we;
  logic [dsp_pkg::WADDR_BITS-1:0] wt_waddr;
  logic [dsp_pkg::WADDR_BITS-1:0] wt_raddr;
  logic [dsp_pkg::WEIGHT_BITS-1:0] wt_rdata;

  logic          d_we;
  logic [NB-1:0] d_waddr;
  logic [SB-1:0] d_wdata;
  logic [NB-1:0] d_raddr;
  logic [SB-1:0] d_rdata;

  logic [SB-1:0] rd_dist;
  logic [SB-1:0] sum_raw;
  logic [SB-1:0] sum_sat;
  logic          relax_better;
  logic          scan_better;

  // clamp node count into 1..MAX_NODES
  always_comb begin
    if (cfg.node_count == '0) begin
      n_eff = CB'(1);
    end else if (int'(cfg.node_count) > dsp_pkg::MAX_NODES) begin
      n_eff = CB'(dsp_pkg::MAX_NODES);
    end else begin
      n_eff = CB'(cfg.node_count);
    end
  end

  assign run_go    = accept && (item.kind == dsp_pkg::KIND_RUN);
  assign start_ok  = int'(cfg.start_node) < int'(n_eff);
  assign fin_ok    = int'(cfg.finish_node) < int'(n_r);
  assign start_idx = NB'(cfg.start_node);
  assign fin_idx   = NB'(cfg.finish_node);
  assign issue     = idx < n_r;

  // matrix loads go straight into the weight RAM
  assign wt_we    = accept && (item.kind == dsp_pkg::KIND_LOAD) &&
                    (int'(item.row) < dsp_pkg::MAX_NODES) &&
                    (int'(item.col) < dsp_pkg::MAX_NODES);
  assign wt_waddr = {NB'(item.row), NB'(item.col)};
  assign wt_raddr = {best, idx[NB-1:0]};

  dsp_ram #(
    .ADDR_BITS (dsp_pkg::WADDR_BITS),
    .DATA_BITS (dsp_pkg::WEIGHT_BITS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (item.weight),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  dsp_ram #(
    .ADDR_BITS (NB),
    .DATA_BITS (SB)
  ) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // entry without a valid bit reads as infinity
  assign rd_dist = pend_valid ? d_rdata : dsp_pkg::DIST_INF;

  assign sum_raw      = {1'b0, bestd[DB-1:0]} + SB'(wt_rdata[dsp_pkg::WEIGHT_BITS-2:0]);
  assign sum_sat      = sum_raw[DB] ? {1'b0, dsp_pkg::DIST_MAX} : sum_raw;
  assign relax_better = !wt_rdata[dsp_pkg::WEIGHT_BITS-1] && (sum_sat < rd_dist);
  assign scan_better  = !pend_vis && (!found || (rd_dist < bestd));

  always_comb begin
    d_we    = 1'b0;
    d_waddr = start_idx;
    d_wdata = '0;
    d_raddr = idx[NB-1:0];
    if (state == S_IDLE) begin
      d_we = run_go && start_ok;
    end else if (state == S_RELAX) begin
      d_we    = pend && relax_better;
      d_waddr = pend_idx;
      d_wdata = sum_sat;
    end else if (state == S_FIN) begin
      d_raddr = fin_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pend    <= 1'b0;
      found   <= 1'b0;
      visited <= '0;
      dvalid  <= '0;
      idx     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (run_go) begin
            visited <= '0;
            n_r     <= n_eff;
            idx     <= '0;
            found   <= 1'b0;
            pend    <= 1'b0;
            if (start_ok) begin
              // only the start entry holds a distance
              dvalid <= MN'(1) << start_idx;
              state  <= S_SCAN;
            end else begin
              dvalid <= '0;
              res    <= '0;
              state  <= S_REPORT;
            end
          end
        end
        S_SCAN: begin
          pend       <= issue;
          pend_idx   <= idx[NB-1:0];
          pend_vis   <= visited[idx[NB-1:0]];
          pend_valid <= dvalid[idx[NB-1:0]];
          if (issue) begin
            idx <= idx + CB'(1);
          end
          // strict compare keeps the lowest index on ties
          if (pend && scan_better) begin
            best  <= pend_idx;
            bestd <= rd_dist;
            found <= 1'b1;
          end
          if (!issue && !pend) begin
            if (!found || bestd[DB]) begin
              state <= S_FIN;
            end else begin
              visited[best] <= 1'b1;
              idx   <= '0;
              state <= S_RELAX;
            end
          end
        end
        S_RELAX: begin
          pend       <= issue;
          pend_idx   <= idx[NB-1:0];
          pend_valid <= dvalid[idx[NB-1:0]];
          if (issue) begin
            idx <= idx + CB'(1);
          end
          if (pend && relax_better) begin
            dvalid[pend_idx] <= 1'b1;
          end
          // the last write lands before the next scan reads
          if (!issue && !pend) begin
            idx   <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_FIN: begin
          pend_valid <= dvalid[fin_idx];
          state      <= S_READ;
        end
        S_READ: begin
          res.reachable <= fin_ok && !rd_dist[DB];
          res.distance  <= (fin_ok && !rd_dist[DB]) ? rd_dist[DB-1:0] : '0;
          state         <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign ready = (state == S_IDLE);
  assign done  = (state == S_REPORT) && out_free;

endmodule

// File: rtl/core/dsp_checker.sv
// dsp_checker: port-level assertions for dense_shortest_path_top, bound in below.
// Depends on dsp_pkg for field widths.
module dsp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_kind,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dsp_pkg::DIST_BITS-1:0] out_distance,
  input logic                          out_reachable
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_reachable))
    else $error("result changed while stalled");

  // unreachable results report zero distance
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reachable |-> out_distance == '0)
    else $error("unreachable result with nonzero distance");

  // loads never stall intake
  a_load_stream: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == dsp_pkg::KIND_LOAD) |=> in_ready)
    else $error("intake stalled after a load");

  // a run blocks intake while it searches
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == dsp_pkg::KIND_RUN) |=> !in_ready)
    else $error("intake open during a run");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind dense_shortest_path_top dsp_checker u_dsp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .in_kind       (items.kind),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_distance  (results.distance),
  .out_reachable (results.reachable)
);
